@@ hdl/bitmap_run_allocator_top_defines.svh @@
// Assertion macros for the bitmap run allocator.
// Expects signals named clk and rst_n in the including scope.
`ifndef BITMAP_RUN_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_RUN_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BRA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap run allocator: implication check failed");

// Next-cycle implication, checked out of reset.
`define BRA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap run allocator: next-cycle check failed");

`endif

@@ hdl/bra_pkg.sv @@
// Shared types and constants for the bitmap run allocator.
// No dependencies; used by bra_div and bitmap_run_allocator_top.
package bra_pkg;

    localparam int MAX_BITS_DEF  = 4096;
    localparam int WORD_BITS_DEF = 32;
    localparam int OPCODE_W      = 3;
    localparam int IDX_W         = 12;
    localparam int CNT_W         = 13;
    // bit positions and run bounds, wide enough for index + count
    localparam int POS_W         = 14;
    localparam int BIU_RESET     = 4096;

    typedef enum logic [OPCODE_W-1:0] {
        OP_FILL        = 3'd0,
        OP_WRITE_BIT   = 3'd1,
        OP_WRITE_RANGE = 3'd2,
        OP_TEST_BIT    = 3'd3,
        OP_FIND_RUN    = 3'd4
    } op_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [IDX_W-1:0]    index;
        logic [CNT_W-1:0]    count;
        logic                value;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] position;
        logic             rejected;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_WALK,
        S_RESP
    } state_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] quot;
        logic [IDX_W-1:0] rem;
    } div_res_t;

endpackage

@@ hdl/bra_div.sv @@
// Splits a bit index into word number and bit offset by reciprocal multiplication;
// the quotient and remainder are registered and flagged by done. Depends on bra_pkg.
module bra_div #(
    parameter int WORD_BITS = bra_pkg::WORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bra_pkg::IDX_W-1:0] dividend,
    output bra_pkg::div_res_t         res
);

    localparam int     IW    = bra_pkg::IDX_W;
    localparam int     SH    = IW + $clog2(WORD_BITS);
    // ceil(2^SH / WORD_BITS) gives the exact quotient for every IW-bit index
    localparam longint RECIP = ((longint'(1) << SH) + longint'(WORD_BITS) - 1)
                               / longint'(WORD_BITS);
    localparam int     RW    = IW + 2;
    localparam int     PW    = IW + RW;

    logic          done_reg;
    logic [IW-1:0] quot_reg, quot_next;
    logic [IW-1:0] rem_reg, rem_next;
    logic [PW-1:0] product;

    always_comb
    begin
        product   = PW'(dividend) * PW'(RECIP);
        quot_next = IW'(product >> SH);
        rem_next  = dividend - quot_next * IW'(WORD_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign res = '{done: done_reg, quot: quot_reg, rem: rem_reg};

endmodule

@@ hdl/bitmap_run_allocator_top.sv @@
// Sequence: request transfer, word split in bra_div (S_DIV), walk of N store words (S_WALK),
// result held in S_RESP; N is up to 128 at defaults for fill and find, one for bit ops, none
// for an empty range. One item at a time: req_stall stays high until the result transfers;
// the walk is a one-word-per-cycle read-modify-write after the split.
// Reset: a clearing pass writes STORE_WORDS words (128 at defaults) with req_stall high;
// bits_in_use resets to 4096.
`include "bitmap_run_allocator_top_defines.svh"

module bitmap_run_allocator_top #(
    parameter int MAX_BITS  = bra_pkg::MAX_BITS_DEF,
    parameter int WORD_BITS = bra_pkg::WORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  bra_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output bra_pkg::rsp_t             rsp,
    input  logic                      cfg_write,
    input  logic [bra_pkg::CNT_W-1:0] cfg_data
);

    localparam int STORE_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int PW          = bra_pkg::POS_W;
    localparam int IW          = bra_pkg::IDX_W;
    localparam int CW          = bra_pkg::CNT_W;
    localparam int OFF_W       = $clog2(WORD_BITS);
    localparam int CNT_MAX     = (1 << CW) - 1;
    localparam int USED_CAP    = (MAX_BITS < CNT_MAX) ? MAX_BITS : CNT_MAX;

    bra_pkg::state_t           state_reg, state_next;
    logic [CW-1:0]             bits_in_use_reg;
    logic [AW-1:0]             clr_addr_reg, clr_addr_next;
    logic                      pend_reg, pend_next;
    logic [bra_pkg::OPCODE_W-1:0] op_reg, op_next;
    logic                      val_reg, val_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [PW-1:0]             start_reg, start_next;
    logic [PW-1:0]             end_reg, end_next;
    logic [AW-1:0]             rd_addr_reg, rd_addr_next;
    logic [PW-1:0]             rd_base_reg, rd_base_next;
    logic [AW-1:0]             proc_addr_reg, proc_addr_next;
    logic [PW-1:0]             proc_base_reg, proc_base_next;
    logic [PW-1:0]             run_start_reg, run_start_next;
    logic                      hit_reg, hit_next;
    logic [IW-1:0]             pos_reg, pos_next;
    logic                      rej_reg, rej_next;

    logic [WORD_BITS-1:0]      mem [STORE_WORDS];
    logic [WORD_BITS-1:0]      rdata_reg;
    logic                      mem_we, mem_re;
    logic [AW-1:0]             mem_waddr;
    logic [WORD_BITS-1:0]      mem_wdata;

    logic                      div_start;
    logic [IW-1:0]             div_dividend;
    bra_pkg::div_res_t         div_res;

    logic [CW-1:0]             used;
    logic [PW-1:0]             used_w, idx_w, req_sum;

    logic [PW-1:0]             abs_pos   [WORD_BITS];
    logic                      has_miss  [WORD_BITS];
    logic [OFF_W-1:0]          last_miss [WORD_BITS];
    logic [PW-1:0]             run_start [WORD_BITS];
    logic [WORD_BITS-1:0]      run_ok;
    logic [WORD_BITS-1:0]      word_mask, word_match, miss;
    logic [WORD_BITS-1:0]      merged;
    logic                      test_hit, found, last_word;
    logic [PW-1:0]             found_full;

    bra_div #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .res      (div_res)
    );

    assign used    = (bits_in_use_reg > CW'(USED_CAP)) ? CW'(USED_CAP) : bits_in_use_reg;
    assign used_w  = PW'(used);
    assign idx_w   = PW'(req.index);
    assign req_sum = idx_w + PW'(req.count);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_in_use_reg <= CW'(bra_pkg::BIU_RESET);
        end
        else if (cfg_write)
        begin
            bits_in_use_reg <= cfg_data;
        end
    end

    // word memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bra_pkg::S_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        val_reg       <= val_next;
        cnt_reg       <= cnt_next;
        start_reg     <= start_next;
        end_reg       <= end_next;
        rd_addr_reg   <= rd_addr_next;
        rd_base_reg   <= rd_base_next;
        proc_addr_reg <= proc_addr_next;
        proc_base_reg <= proc_base_next;
        run_start_reg <= run_start_next;
        hit_reg       <= hit_next;
        pos_reg       <= pos_next;
        rej_reg       <= rej_next;
    end

    // per-word datapath: range mask, merge, and run search across the word
    always_comb
    begin
        word_match = ~(rdata_reg ^ {WORD_BITS{val_reg}});
        for (int j = 0; j < WORD_BITS; j++)
        begin
            abs_pos[j]   = proc_base_reg + PW'(j);
            word_mask[j] = (abs_pos[j] >= start_reg) && (abs_pos[j] < end_reg);
        end
        miss = ~(word_mask & word_match);
        for (int j = 0; j < WORD_BITS; j++)
        begin
            has_miss[j]  = 1'b0;
            last_miss[j] = '0;
            for (int m = 0; m < WORD_BITS; m++)
            begin
                if (m <= j && miss[m])
                begin
                    has_miss[j]  = 1'b1;
                    last_miss[j] = OFF_W'(m);
                end
            end
            run_start[j] = has_miss[j] ? proc_base_reg + PW'(last_miss[j]) + PW'(1)
                                       : run_start_reg;
            run_ok[j]    = word_mask[j] && word_match[j]
                           && (abs_pos[j] + PW'(1) >= run_start[j] + PW'(cnt_reg));
        end
        // lowest qualifying bit wins
        found      = 1'b0;
        found_full = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (run_ok[j])
            begin
                found      = 1'b1;
                found_full = abs_pos[j] + PW'(1) - PW'(cnt_reg);
            end
        end
        merged    = val_reg ? (rdata_reg | word_mask) : (rdata_reg & ~word_mask);
        test_hit  = |(word_mask & word_match);
        last_word = (proc_base_reg + PW'(WORD_BITS)) >= end_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        pend_next      = pend_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        cnt_next       = cnt_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        rd_addr_next   = rd_addr_reg;
        rd_base_next   = rd_base_reg;
        proc_addr_next = proc_addr_reg;
        proc_base_next = proc_base_reg;
        run_start_next = run_start_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        rej_next       = rej_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        div_start      = 1'b0;
        div_dividend   = '0;

        unique case (state_reg)
            bra_pkg::S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(STORE_WORDS - 1))
                begin
                    state_next = bra_pkg::S_IDLE;
                end
            end

            bra_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next        = req.opcode;
                    val_next       = req.value;
                    cnt_next       = req.count;
                    run_start_next = idx_w;
                    hit_next       = 1'b0;
                    pos_next       = '0;
                    rej_next       = 1'b0;
                    start_next     = idx_w;
                    end_next       = idx_w;
                    // an empty range (start == end) skips the walk
                    unique case (bra_pkg::op_t'(req.opcode))
                        bra_pkg::OP_FILL:
                        begin
                            start_next = '0;
                            end_next   = used_w;
                        end
                        bra_pkg::OP_WRITE_BIT:
                        begin
                            if (idx_w >= used_w)
                                rej_next = 1'b1;
                            else
                                end_next = idx_w + PW'(1);
                        end
                        bra_pkg::OP_WRITE_RANGE:
                        begin
                            if (req_sum > used_w)
                                rej_next = 1'b1;
                            else
                                end_next = req_sum;
                        end
                        bra_pkg::OP_TEST_BIT:
                        begin
                            if (idx_w < used_w)
                                end_next = idx_w + PW'(1);
                        end
                        bra_pkg::OP_FIND_RUN:
                        begin
                            if (req.count != '0 && idx_w < used_w)
                                end_next = used_w;
                        end
                        default:
                        begin
                        end
                    endcase
                    div_start    = 1'b1;
                    div_dividend = start_next[IW-1:0];
                    state_next   = bra_pkg::S_DIV;
                end
            end

            bra_pkg::S_DIV:
            begin
                if (div_res.done)
                begin
                    rd_addr_next = AW'(div_res.quot);
                    rd_base_next = start_reg - PW'(div_res.rem);
                    pend_next    = 1'b0;
                    state_next   = (start_reg < end_reg) ? bra_pkg::S_WALK : bra_pkg::S_RESP;
                end
            end

            bra_pkg::S_WALK:
            begin
                // read ahead one word while the previous one is modified
                if (rd_base_reg < end_reg)
                begin
                    mem_re         = 1'b1;
                    rd_addr_next   = rd_addr_reg + AW'(1);
                    rd_base_next   = rd_base_reg + PW'(WORD_BITS);
                    proc_addr_next = rd_addr_reg;
                    proc_base_next = rd_base_reg;
                    pend_next      = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    unique case (bra_pkg::op_t'(op_reg))
                        bra_pkg::OP_FILL,
                        bra_pkg::OP_WRITE_BIT,
                        bra_pkg::OP_WRITE_RANGE:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = proc_addr_reg;
                            mem_wdata = merged;
                        end
                        bra_pkg::OP_TEST_BIT:
                        begin
                            hit_next = test_hit;
                        end
                        bra_pkg::OP_FIND_RUN:
                        begin
                            run_start_next = run_start[WORD_BITS-1];
                            if (found)
                            begin
                                hit_next = 1'b1;
                                pos_next = found_full[IW-1:0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if ((op_reg == bra_pkg::OP_FIND_RUN && found) || last_word)
                    begin
                        pend_next  = 1'b0;
                        state_next = bra_pkg::S_RESP;
                    end
                end
            end

            bra_pkg::S_RESP:
            begin
                if (!rsp_stall)
                begin
                    state_next = bra_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bra_pkg::S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != bra_pkg::S_IDLE);
    assign rsp_valid = (state_reg == bra_pkg::S_RESP);
    assign rsp       = '{hit: hit_reg, position: pos_reg, rejected: rej_reg};

    `BRA_ASSERT_NXT(a_one_result, rsp_valid && !rsp_stall, !rsp_valid)
    `BRA_ASSERT_IMP(a_no_rw_collide, mem_we && mem_re, mem_waddr != rd_addr_reg)
    `BRA_ASSERT_IMP(a_div_in_div_state, div_res.done, state_reg == bra_pkg::S_DIV)
    `BRA_ASSERT_IMP(a_run_in_bounds, rsp_valid && rsp.hit && op_reg == bra_pkg::OP_FIND_RUN, PW'(rsp.position) + PW'(cnt_reg) <= used_w)

endmodule

@@ tb/sv/tb_bitmap_run_allocator_top.sv @@
// Self-checking bench for bitmap_run_allocator_top: shadow bitmap, queued
// request driver, response monitor. Depends on bra_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_bitmap_run_allocator_top;

    localparam int STORE_BITS  = bra_pkg::MAX_BITS_DEF;
    localparam int OW          = bra_pkg::OPCODE_W;
    localparam int IW          = bra_pkg::IDX_W;
    localparam int CW          = bra_pkg::CNT_W;
    localparam int PHASE_ITEMS = 78;
    localparam int LONG_HOLD   = 600;
    localparam int SETTLE      = 24;
    localparam int IDLE_LIMIT  = 5000;

    // opcodes with no operation behind them
    localparam logic [OW-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OW-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OW-1:0] OP_SPARE_C = 3'd7;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    bra_pkg::req_t    req = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    bra_pkg::rsp_t    rsp;
    logic             cfg_write = 1'b0;
    logic [CW-1:0]    cfg_data = '0;

    bit [0:STORE_BITS-1] shadow_bits;
    int   bits_in_use_model = bra_pkg::BIU_RESET;

    bra_pkg::req_t pending_req[$];
    bra_pkg::rsp_t expected_rsp[$];
    bra_pkg::rsp_t want;

    int   n_queued;
    int   n_accepted;
    int   n_results;
    int   mismatch_count;
    int   idle_cycles;
    int   send_gap;
    int   stall_left;
    int   hold_asked;
    int   hold_served;
    int   n_settings;
    bit   req_taken;
    bit   no_idle;

    bitmap_run_allocator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Apply one request to the shadow bitmap and return the response it must produce.
    function automatic bra_pkg::rsp_t predict_response(bra_pkg::req_t r);
        bra_pkg::rsp_t res;
        int   used;
        int   idx;
        int   cnt;
        int   run;
        res  = '0;
        used = (bits_in_use_model > STORE_BITS) ? STORE_BITS : bits_in_use_model;
        idx  = int'(r.index);
        cnt  = int'(r.count);
        case (r.opcode)
            bra_pkg::OP_FILL:
                for (int i = 0; i < used; i++)
                    shadow_bits[i] = r.value;
            bra_pkg::OP_WRITE_BIT:
                if (idx >= used)
                    res.rejected = 1'b1;
                else
                    shadow_bits[idx] = r.value;
            bra_pkg::OP_WRITE_RANGE:
                if (idx + cnt > used)
                    res.rejected = 1'b1;
                else
                    for (int i = idx; i < idx + cnt; i++)
                        shadow_bits[i] = r.value;
            bra_pkg::OP_TEST_BIT:
                res.hit = (idx < used) && (shadow_bits[idx] == r.value);
            bra_pkg::OP_FIND_RUN:
                if (cnt != 0)
                begin
                    run = 0;
                    for (int i = idx; i < used; i++)
                    begin
                        if (shadow_bits[i] == r.value)
                        begin
                            run++;
                            if (run == cnt)
                            begin
                                res.hit      = 1'b1;
                                res.position = IW'(i + 1 - cnt);
                                break;
                            end
                        end
                        else
                            run = 0;
                    end
                end
            default:
                ;
        endcase
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bra_pkg::req_t random_request(int cfg_bits);
        bra_pkg::req_t r;
        int   used;
        int   room;
        int   sel;
        used = (cfg_bits > STORE_BITS) ? STORE_BITS : cfg_bits;
        sel  = $urandom_range(0, 99);
        if (sel < 4)
            r.opcode = bra_pkg::OP_FILL;
        else if (sel < 28)
            r.opcode = bra_pkg::OP_WRITE_BIT;
        else if (sel < 50)
            r.opcode = bra_pkg::OP_WRITE_RANGE;
        else if (sel < 72)
            r.opcode = bra_pkg::OP_TEST_BIT;
        else if (sel < 95)
            r.opcode = bra_pkg::OP_FIND_RUN;
        else
            r.opcode = OW'($urandom_range(OP_SPARE_A, OP_SPARE_C));
        if (used > 0 && $urandom_range(0, 4) != 0)
            r.index = IW'($urandom_range(0, used - 1));
        else
            r.index = IW'($urandom_range(0, STORE_BITS - 1));
        sel = $urandom_range(0, 9);
        if (sel < 4)
            r.count = CW'($urandom_range(0, 8));
        else if (sel < 7)
            r.count = CW'($urandom_range(0, 64));
        else if (sel < 9)
        begin
            // land on, or just past, the end of the in-use bits
            room = used - int'(r.index);
            if (room < 0)
                room = 0;
            r.count = CW'($urandom_range(0, room + 1));
        end
        else
            r.count = CW'($urandom_range(0, (1 << CW) - 1));
        r.value = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic queue_request(logic [OW-1:0] op, int idx, int cnt, bit val);
        bra_pkg::req_t r;
        r.opcode = op;
        r.index  = IW'(idx);
        r.count  = CW'(cnt);
        r.value  = val;
        pending_req.push_back(r);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_bits_in_use(int v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= CW'(v);
        bits_in_use_model = v;
        n_settings++;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Request driver: present the next pending item once the last one transferred.
    always @(negedge clk)
    begin
        if (!req_valid || req_taken)
        begin
            req_taken = 1'b0;
            if (send_gap > 0)
            begin
                req_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_req.size() > 0)
            begin
                req       <= pending_req.pop_front();
                req_valid <= 1'b1;
                if (!no_idle && $urandom_range(0, 2) == 0)
                    send_gap = pick_gap();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Response side back-pressure, with an occasional long hold on request.
    always @(negedge clk)
    begin
        if (hold_served != hold_asked)
        begin
            hold_served = hold_asked;
            stall_left  = LONG_HOLD;
        end
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if (!no_idle && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // Predict on each request transfer, check each response transfer in order.
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
        begin
            expected_rsp.push_back(predict_response(req));
            n_accepted++;
            req_taken = 1'b1;
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            n_results++;
            if (expected_rsp.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected response hit=%0d position=%0d rejected=%0d",
                             rsp.hit, rsp.position, rsp.rejected);
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.hit !== want.hit || rsp.position !== want.position ||
                    rsp.rejected !== want.rejected)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: response %0d: expected hit=%0d position=%0d rejected=%0d, got hit=%0d position=%0d rejected=%0d",
                                 n_results, want.hit, want.position, want.rejected,
                                 rsp.hit, rsp.position, rsp.rejected);
                end
            end
        end
    end

    // Abort when no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ERROR: no transfer for %0d cycles, %0d responses outstanding",
                     idle_cycles, expected_rsp.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int cfg_plan[13];
        cfg_plan = '{0, 1, 31, 32, 33, 100, 257, 1000, 4095, 8191, 4096, 64, 2048};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Edges of the full map at reset width.
        queue_request(bra_pkg::OP_FIND_RUN, 0, 4096, 1'b0);
        queue_request(bra_pkg::OP_WRITE_BIT, 4095, 0, 1'b1);
        queue_request(bra_pkg::OP_TEST_BIT, 4095, 0, 1'b1);
        queue_request(bra_pkg::OP_FIND_RUN, 0, 1, 1'b1);
        queue_request(bra_pkg::OP_WRITE_RANGE, 4090, 6, 1'b1);
        queue_request(bra_pkg::OP_WRITE_RANGE, 4090, 7, 1'b1);
        queue_request(bra_pkg::OP_WRITE_RANGE, 4095, 0, 1'b1);
        queue_request(bra_pkg::OP_FIND_RUN, 4090, 7, 1'b1);
        queue_request(bra_pkg::OP_FIND_RUN, 4085, 6, 1'b1);
        queue_request(bra_pkg::OP_FIND_RUN, 0, 0, 1'b0);
        queue_request(bra_pkg::OP_FIND_RUN, 0, 8191, 1'b0);
        queue_request(OP_SPARE_A, 4095, 8191, 1'b1);
        queue_request(OP_SPARE_B, 0, 0, 1'b0);
        queue_request(OP_SPARE_C, 1234, 77, 1'b1);
        queue_request(bra_pkg::OP_FILL, 0, 0, 1'b1);
        queue_request(bra_pkg::OP_TEST_BIT, 0, 0, 1'b1);
        queue_request(bra_pkg::OP_FIND_RUN, 0, 1, 1'b0);
        queue_request(bra_pkg::OP_WRITE_BIT, 0, 0, 1'b0);
        wait_drained();

        // Short map: everything past the end is rejected or left alone.
        write_bits_in_use(100);
        queue_request(bra_pkg::OP_WRITE_BIT, 100, 0, 1'b1);
        queue_request(bra_pkg::OP_WRITE_BIT, 99, 0, 1'b0);
        queue_request(bra_pkg::OP_TEST_BIT, 100, 0, 1'b1);
        queue_request(bra_pkg::OP_WRITE_RANGE, 95, 6, 1'b0);
        queue_request(bra_pkg::OP_WRITE_RANGE, 100, 0, 1'b0);
        queue_request(bra_pkg::OP_FILL, 0, 0, 1'b0);
        queue_request(bra_pkg::OP_FIND_RUN, 0, 100, 1'b0);
        wait_drained();

        foreach (cfg_plan[p])
        begin
            write_bits_in_use(cfg_plan[p]);
            no_idle = (p % 4 == 2);
            // hold responses while requests keep coming, so the input backs up
            if (cfg_plan[p] == 1000)
                hold_asked++;
            for (int k = 0; k < PHASE_ITEMS; k++)
                pending_req.push_back(random_request(cfg_plan[p]));
            n_queued += PHASE_ITEMS;
            wait_drained();
        end
        no_idle = 1'b0;

        repeat (40) @(posedge clk);
        $display("Summary: %0d requests and %0d responses over %0d bits-in-use settings",
                 n_accepted, n_results, n_settings);
        $display("  (range 0 to 8191, all opcodes, rejects, one long response hold)");
        if (mismatch_count == 0 && expected_rsp.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
